@@ src/rpd_pkg.sv @@
// shared constants and result codes for the receive deframer
package rpd_pkg;

    localparam logic [7:0] START_IDENT = 8'h1C;
    localparam logic [7:0] START_DATA  = 8'hFA;
    localparam logic [7:0] END_IDENT   = 8'h1F;
    localparam logic [7:0] END_DATA    = 8'hFB;

    localparam logic [7:0] TYPE_ROUTE = 8'h00;
    localparam logic [7:0] TYPE_KEYS  = 8'h01;
    localparam logic [7:0] TYPE_CELLS = 8'h02;

    localparam logic [3:0] POS_HUNT       = 4'd0;
    localparam logic [3:0] POS_FIRST      = 4'd1;
    localparam logic [3:0] POS_CHECK      = 4'd8;
    localparam logic [3:0] POS_LAST_IDENT = 4'd3;
    localparam logic [3:0] POS_LAST_DATA  = 4'd9;

    localparam int STORE_DEPTH = 8;

    typedef enum logic [2:0] {
        KIND_IDENT  = 3'd0,
        KIND_ROUTE  = 3'd1,
        KIND_KEYS   = 3'd2,
        KIND_CELLS  = 3'd3,
        KIND_OTHER  = 3'd4,
        KIND_BADSUM = 3'd5,
        KIND_BADEND = 3'd6
    } result_kind_t;

    typedef enum logic {
        FMT_IDENT = 1'b0,
        FMT_DATA  = 1'b1
    } frame_fmt_t;

endpackage

@@ src/rx_packet_deframer_checksum.sv @@
// byte-serial receive deframer with checksum check and frame decode
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_stall | rx_byte
//  out     | output    | out_valid/out_stall | result_kind, ident_first, ident_second,
//          |           |                     | packet_type, count_byte, data_value,
//          |           |                     | key_bitmap
//
//  one byte per cycle while in_stall is low; a closing byte's decode lands in the result register
//  and appears on out in the cycle after its transaction
//  reset returns the frame tracker to hunting and empties the result register
//  in_stall rises only while a result is held and out_stall is high, since the
//  single result register is then the only place a new result could go
module rx_packet_deframer_checksum
    import rpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [7:0]  ident_first,
    output logic [7:0]  ident_second,
    output logic [7:0]  packet_type,
    output logic [7:0]  count_byte,
    output logic [7:0]  data_value,
    output logic [31:0] key_bitmap
);

    logic [3:0]  pos_reg, pos_next;
    frame_fmt_t  fmt_reg, fmt_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    logic        out_valid_reg;
    result_kind_t kind_reg, kind_next;
    logic [7:0]  ident_first_reg, ident_first_next;
    logic [7:0]  ident_second_reg, ident_second_next;
    logic [7:0]  packet_type_reg, packet_type_next;
    logic [7:0]  count_byte_reg, count_byte_next;
    logic [7:0]  data_value_reg, data_value_next;
    logic [31:0] key_bitmap_reg, key_bitmap_next;

    logic        fire;
    logic        last_byte;
    logic        store_we;
    logic [2:0]  store_idx;

    assign in_stall  = out_valid_reg && out_stall;
    assign fire      = in_valid && !in_stall;
    assign last_byte = (pos_reg != POS_HUNT) &&
                       (pos_reg == ((fmt_reg == FMT_DATA) ? POS_LAST_DATA : POS_LAST_IDENT));
    assign store_idx = 3'(pos_reg - POS_FIRST);
    assign store_we  = fire && (pos_reg != POS_HUNT) && !last_byte;

    // frame tracking
    always_comb
    begin
        pos_next = pos_reg;
        fmt_next = fmt_reg;
        sum_next = sum_reg;
        if (fire)
        begin
            if (pos_reg == POS_HUNT)
            begin
                if (rx_byte == START_IDENT)
                begin
                    fmt_next = FMT_IDENT;
                    sum_next = rx_byte;
                    pos_next = POS_FIRST;
                end
                else if (rx_byte == START_DATA)
                begin
                    fmt_next = FMT_DATA;
                    sum_next = rx_byte;
                    pos_next = POS_FIRST;
                end
            end
            else if (!last_byte)
            begin
                // checksum byte is stored but kept out of the sum
                if (pos_reg != POS_CHECK)
                begin
                    sum_next = sum_reg + rx_byte;
                end
                pos_next = pos_reg + 4'd1;
            end
            else
            begin
                pos_next = POS_HUNT;
                fmt_next = FMT_IDENT;
                sum_next = 8'h00;
            end
        end
    end

    // decode of the closing byte
    always_comb
    begin
        kind_next         = KIND_IDENT;
        ident_first_next  = 8'h00;
        ident_second_next = 8'h00;
        packet_type_next  = 8'h00;
        count_byte_next   = 8'h00;
        data_value_next   = 8'h00;
        key_bitmap_next   = 32'h0;
        if (fmt_reg == FMT_IDENT)
        begin
            if (rx_byte != END_IDENT)
            begin
                kind_next = KIND_BADEND;
            end
            else
            begin
                kind_next         = KIND_IDENT;
                ident_first_next  = store_reg[0];
                ident_second_next = store_reg[1];
            end
        end
        else if (rx_byte != END_DATA)
        begin
            kind_next = KIND_BADEND;
        end
        else if (8'(sum_reg + rx_byte) != store_reg[7])
        begin
            kind_next = KIND_BADSUM;
        end
        else
        begin
            packet_type_next = store_reg[0];
            count_byte_next  = store_reg[1];
            case (store_reg[0])
                TYPE_ROUTE:
                begin
                    kind_next       = KIND_ROUTE;
                    data_value_next = store_reg[2];
                end
                TYPE_KEYS:
                begin
                    kind_next       = KIND_KEYS;
                    key_bitmap_next = {store_reg[6], store_reg[5], store_reg[4], store_reg[3]};
                end
                TYPE_CELLS:
                begin
                    kind_next       = KIND_CELLS;
                    data_value_next = store_reg[2];
                end
                default:
                begin
                    kind_next = KIND_OTHER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_HUNT;
            fmt_reg       <= FMT_IDENT;
            sum_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            fmt_reg <= fmt_next;
            sum_reg <= sum_next;
            if (fire && last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= rx_byte;
        end
        if (fire && last_byte)
        begin
            kind_reg         <= kind_next;
            ident_first_reg  <= ident_first_next;
            ident_second_reg <= ident_second_next;
            packet_type_reg  <= packet_type_next;
            count_byte_reg   <= count_byte_next;
            data_value_reg   <= data_value_next;
            key_bitmap_reg   <= key_bitmap_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign ident_first  = ident_first_reg;
    assign ident_second = ident_second_reg;
    assign packet_type  = packet_type_reg;
    assign count_byte   = count_byte_reg;
    assign data_value   = data_value_reg;
    assign key_bitmap   = key_bitmap_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST_DATA)
        else $error("frame position past end of data packet");

    a_ident_len: assert property (@(posedge clk) disable iff (!rst_n)
        (fmt_reg == FMT_IDENT) |-> (pos_reg <= POS_LAST_IDENT))
        else $error("identity reply longer than four bytes");

    a_close_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> (pos_reg == POS_HUNT) && out_valid_reg)
        else $error("closing byte did not give a result and resume hunting");

    a_ident_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_IDENT)) |->
            (ident_first_reg == 8'h00) && (ident_second_reg == 8'h00))
        else $error("identity bytes leak into a non-identity result");

endmodule

@@ dv/rx_packet_deframer_checksum_test.sv @@
// self-checking testbench for the receive deframer with checksum
module rx_packet_deframer_checksum_test;
    import rpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STREAM_BYTES = 1050;
    localparam int QUIET_TAIL   = 120;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_END
    } flaw_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   ident_first;
        logic [7:0]   ident_second;
        logic [7:0]   packet_type;
        logic [7:0]   count_byte;
        logic [7:0]   data_value;
        logic [31:0]  key_bitmap;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  result_kind;
    logic [7:0]  ident_first;
    logic [7:0]  ident_second;
    logic [7:0]  packet_type;
    logic [7:0]  count_byte;
    logic [7:0]  data_value;
    logic [31:0] key_bitmap;

    rx_packet_deframer_checksum dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .ident_first  (ident_first),
        .ident_second (ident_second),
        .packet_type  (packet_type),
        .count_byte   (count_byte),
        .data_value   (data_value),
        .key_bitmap   (key_bitmap)
    );

    always #5 clk = ~clk;

    logic [7:0]    link_bytes[$];
    frame_result_t decoded_frames[$];
    int            error_count = 0;
    bit            in_taken = 1'b0;
    int            send_gap = 0;
    int            stall_left = 0;

    // predictor state
    logic [3:0] frame_pos = POS_HUNT;
    frame_fmt_t frame_fmt = FMT_IDENT;
    logic [7:0] frame_sum = 8'h00;
    logic [7:0] field_bytes [STORE_DEPTH];

    task automatic absorb_byte(input logic [7:0] b);
        frame_result_t r;
        logic [3:0]    last_pos;
        if (frame_pos == POS_HUNT) begin
            if (b == START_IDENT || b == START_DATA) begin
                frame_fmt = (b == START_DATA) ? FMT_DATA : FMT_IDENT;
                frame_sum = b;
                frame_pos = POS_FIRST;
            end
        end
        else begin
            last_pos = (frame_fmt == FMT_DATA) ? POS_LAST_DATA : POS_LAST_IDENT;
            if (frame_pos != last_pos) begin
                field_bytes[3'(frame_pos - 4'd1)] = b;
                // the checksum byte itself stays out of the sum
                if (frame_pos != POS_CHECK)
                    frame_sum = frame_sum + b;
                frame_pos = frame_pos + 4'd1;
            end
            else begin
                r = '0;
                if (frame_fmt == FMT_IDENT) begin
                    if (b != END_IDENT)
                        r.kind = KIND_BADEND;
                    else
                    begin
                        r.kind = KIND_IDENT;
                        r.ident_first = field_bytes[0];
                        r.ident_second = field_bytes[1];
                    end
                end
                else if (b != END_DATA)
                    r.kind = KIND_BADEND;
                else if (8'(frame_sum + b) != field_bytes[7])
                    r.kind = KIND_BADSUM;
                else
                begin
                    r.packet_type = field_bytes[0];
                    r.count_byte = field_bytes[1];
                    case (field_bytes[0])
                        TYPE_ROUTE:
                        begin
                            r.kind = KIND_ROUTE;
                            r.data_value = field_bytes[2];
                        end
                        TYPE_KEYS:
                        begin
                            r.kind = KIND_KEYS;
                            r.key_bitmap = {field_bytes[6], field_bytes[5],
                                            field_bytes[4], field_bytes[3]};
                        end
                        TYPE_CELLS:
                        begin
                            r.kind = KIND_CELLS;
                            r.data_value = field_bytes[2];
                        end
                        default:
                            r.kind = KIND_OTHER;
                    endcase
                end
                decoded_frames.push_back(r);
                frame_pos = POS_HUNT;
                frame_fmt = FMT_IDENT;
                frame_sum = 8'h00;
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic queue_ident(input logic [7:0] id1, input logic [7:0] id2,
                               input logic [7:0] tail);
        link_bytes.push_back(START_IDENT);
        link_bytes.push_back(id1);
        link_bytes.push_back(id2);
        link_bytes.push_back(tail);
    endtask

    task automatic queue_packet(input logic [7:0] ptype, input logic [7:0] count,
                                input logic [7:0] data, input logic [31:0] keys,
                                input flaw_t flaw);
        logic [7:0] cs;
        logic [7:0] tail;
        cs = START_DATA + END_DATA + ptype + count + data
             + keys[7:0] + keys[15:8] + keys[23:16] + keys[31:24];
        if (flaw == FLAW_SUM)
            cs = cs + 8'($urandom_range(1, 255));
        tail = END_DATA;
        if (flaw == FLAW_END) begin
            do
                tail = 8'($urandom_range(0, 255));
            while (tail == END_DATA);
        end
        link_bytes.push_back(START_DATA);
        link_bytes.push_back(ptype);
        link_bytes.push_back(count);
        link_bytes.push_back(data);
        link_bytes.push_back(keys[7:0]);
        link_bytes.push_back(keys[15:8]);
        link_bytes.push_back(keys[23:16]);
        link_bytes.push_back(keys[31:24]);
        link_bytes.push_back(cs);
        link_bytes.push_back(tail);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 4))
            0: return TYPE_ROUTE;
            1: return TYPE_KEYS;
            2: return TYPE_CELLS;
            3: return 8'($urandom_range(3, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sender: next byte goes out once the current one is taken
    always @(negedge clk) begin
        logic       next_valid;
        logic [7:0] next_byte;
        next_valid = in_valid;
        next_byte = rx_byte;
        if (rst_n && (!in_valid || in_taken)) begin
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (link_bytes.size() > 0) begin
                if (link_bytes.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(0, 9);
                else
                begin
                    next_valid = 1'b1;
                    next_byte = link_bytes.pop_front();
                end
            end
        end
        in_valid <= next_valid;
        rx_byte <= next_byte;
    end

    // receiver back-pressure in bursts
    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_left > 0)
                stall_left--;
            else if (link_bytes.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        frame_result_t want;
        in_taken = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (decoded_frames.size() == 0) begin
                    $error("result with no transaction awaiting it, result_kind %0d",
                           result_kind);
                    error_count++;
                end
                else
                begin
                    want = decoded_frames.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(result_kind));
                    check_field("ident_first", 32'(want.ident_first), 32'(ident_first));
                    check_field("ident_second", 32'(want.ident_second), 32'(ident_second));
                    check_field("packet_type", 32'(want.packet_type), 32'(packet_type));
                    check_field("count_byte", 32'(want.count_byte), 32'(count_byte));
                    check_field("data_value", 32'(want.data_value), 32'(data_value));
                    check_field("key_bitmap", want.key_bitmap, key_bitmap);
                end
            end
            if (in_valid && !in_stall) begin
                in_taken = 1'b1;
                absorb_byte(rx_byte);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int pick;
        int n;

        // directed: dropped noise, identity extremes, start bytes as payload,
        // bad identity end, key bitmap order, bad checksum with extreme fields
        link_bytes.push_back(8'h00);
        queue_ident(8'hFF, 8'h00, END_IDENT);
        queue_ident(START_IDENT, START_DATA, 8'h00);
        queue_packet(TYPE_KEYS, 8'hFF, 8'h00, 32'h55AA_00FF, FLAW_NONE);
        queue_packet(8'hFF, 8'h00, 8'hFF, 32'hFFFF_FFFF, FLAW_SUM);

        while (link_bytes.size() < STREAM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                queue_packet(pick_type(), 8'($urandom), 8'($urandom), $urandom, FLAW_NONE);
            else if (pick < 70)
                queue_ident(8'($urandom), 8'($urandom), END_IDENT);
            else if (pick < 78)
                queue_packet(pick_type(), 8'($urandom), 8'($urandom), $urandom, FLAW_SUM);
            else if (pick < 85)
                queue_packet(pick_type(), 8'($urandom), 8'($urandom), $urandom, FLAW_END);
            else if (pick < 90)
                queue_ident(8'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 95)
                link_bytes.push_back(8'($urandom));
            else
            begin
                // frame cut short, the next frame's bytes run into it
                link_bytes.push_back($urandom_range(0, 1) ? START_DATA : START_IDENT);
                n = $urandom_range(1, 5);
                repeat (n) link_bytes.push_back(8'($urandom));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        while (link_bytes.size() != 0 || in_valid || decoded_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ rx_packet_deframer_checksum.f @@
src/rpd_pkg.sv
src/rx_packet_deframer_checksum.sv
dv/rx_packet_deframer_checksum_test.sv
